FILE: sv/marching_squares_cell_unit_defines.svh
// assertion macros for the marching squares cell unit
`ifndef MARCHING_SQUARES_CELL_UNIT_DEFINES_SVH
`define MARCHING_SQUARES_CELL_UNIT_DEFINES_SVH
// same-cycle implication, checked outside reset
`define MSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked outside reset
`define MSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: sv/msc_pkg.sv
// types and constants of the marching squares cell unit
package msc_pkg;
	localparam int COORD_W = 29;
	localparam int EDGE_W = 26;
	localparam int POS_W = 12;
	localparam int DIM_W = 13;
	localparam int REG_IDX_W = 3;

	typedef enum logic [1:0] {SIDE_TOP, SIDE_BOTTOM, SIDE_LEFT, SIDE_RIGHT} side_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RASTER_COLUMNS,
		REG_RASTER_ROWS,
		REG_BLOCK_FIRST_ROW,
		REG_BLOCK_FIRST_COL,
		REG_BLOCK_ROWS,
		REG_BLOCK_COLS
	} reg_idx_t;

	typedef struct packed {
		side_t first;
		side_t second;
	} seg_t;

	typedef struct packed {
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
		side_t             entry_side;
		side_t             exit_side;
		logic              last;
		logic [EDGE_W-1:0] edge_idx;
		logic              blk;
		logic              ras;
	} meta_t;

	// start and end side of a segment, second selects the saddle's later segment
	function automatic seg_t seg_sides(input logic [3:0] key, input logic second);
		seg_t s;
		s = seg_t'{SIDE_TOP, SIDE_TOP};
		case (key)
			4'd1:  s = seg_t'{SIDE_LEFT, SIDE_BOTTOM};
			4'd2:  s = seg_t'{SIDE_BOTTOM, SIDE_RIGHT};
			4'd3:  s = seg_t'{SIDE_LEFT, SIDE_RIGHT};
			4'd4:  s = seg_t'{SIDE_RIGHT, SIDE_TOP};
			4'd5:  s = second ? seg_t'{SIDE_RIGHT, SIDE_BOTTOM} : seg_t'{SIDE_LEFT, SIDE_TOP};
			4'd6:  s = seg_t'{SIDE_BOTTOM, SIDE_TOP};
			4'd7:  s = seg_t'{SIDE_LEFT, SIDE_TOP};
			4'd8:  s = seg_t'{SIDE_TOP, SIDE_LEFT};
			4'd9:  s = seg_t'{SIDE_TOP, SIDE_BOTTOM};
			4'd10: s = second ? seg_t'{SIDE_BOTTOM, SIDE_LEFT} : seg_t'{SIDE_TOP, SIDE_RIGHT};
			4'd11: s = seg_t'{SIDE_TOP, SIDE_RIGHT};
			4'd12: s = seg_t'{SIDE_RIGHT, SIDE_LEFT};
			4'd13: s = seg_t'{SIDE_RIGHT, SIDE_BOTTOM};
			4'd14: s = seg_t'{SIDE_BOTTOM, SIDE_LEFT};
			default: s = seg_t'{SIDE_TOP, SIDE_TOP};
		endcase
		return s;
	endfunction
endpackage

FILE: sv/marching_squares_cell_unit.sv
// valid follows an accepted request through stage 1, stage 2, the divider stages and the output register
// throughput: one request per cycle unless busy; a saddle gives two segments and holds busy one cycle
// the two restoring dividers give one quotient bit per pipeline stage
// reset: arst_n clears all valid bits, busy and the configuration registers to their defaults
// results cannot be stalled by the receiver, so the pipeline always advances
`include "marching_squares_cell_unit_defines.svh"
module marching_squares_cell_unit import msc_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [POS_W-1:0]              sq_row,
	input  logic [POS_W-1:0]              sq_col,
	input  logic signed [SAMPLE_BITS-1:0] lower_left,
	input  logic signed [SAMPLE_BITS-1:0] lower_right,
	input  logic signed [SAMPLE_BITS-1:0] upper_right,
	input  logic signed [SAMPLE_BITS-1:0] upper_left,
	input  logic signed [SAMPLE_BITS-1:0] contour_level,
	input  logic                          cfg_we,
	input  logic [REG_IDX_W-1:0]          cfg_index,
	input  logic [DIM_W-1:0]              cfg_data,
	output logic                          valid,
	output logic [COORD_W-1:0]            start_x,
	output logic [COORD_W-1:0]            start_y,
	output logic [COORD_W-1:0]            end_x,
	output logic [COORD_W-1:0]            end_y,
	output logic [EDGE_W-1:0]             start_edge,
	output logic [1:0]                    entry_side,
	output logic [1:0]                    exit_side,
	output logic                          block_inbound,
	output logic                          raster_inbound,
	output logic signed [SAMPLE_BITS-1:0] level_echo,
	output logic                          last_segment
);
	localparam int DW = SAMPLE_BITS + 1;
	localparam int NS = FRAC_BITS + 1;
	localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	typedef logic signed [SAMPLE_BITS-1:0] smp_t;

	// configuration
	logic [DIM_W-1:0] raster_columns_q, raster_rows_q;
	logic [POS_W-1:0] block_first_row_q, block_first_col_q, block_rows_q, block_cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raster_columns_q  <= DIM_W'(4096);
			raster_rows_q     <= DIM_W'(4096);
			block_first_row_q <= '0;
			block_first_col_q <= '0;
			block_rows_q      <= POS_W'(32);
			block_cols_q      <= POS_W'(32);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RASTER_COLUMNS:  raster_columns_q  <= cfg_data;
				REG_RASTER_ROWS:     raster_rows_q     <= cfg_data;
				REG_BLOCK_FIRST_ROW: block_first_row_q <= cfg_data[POS_W-1:0];
				REG_BLOCK_FIRST_COL: block_first_col_q <= cfg_data[POS_W-1:0];
				REG_BLOCK_ROWS:      block_rows_q      <= cfg_data[POS_W-1:0];
				REG_BLOCK_COLS:      block_cols_q      <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [DW-1:0] absd(input smp_t x, input smp_t y);
		logic signed [DW:0] d;
		d = (DW+1)'(x) - (DW+1)'(y);
		return d[DW] ? DW'(-d) : DW'(d);
	endfunction

	// stage 1: request capture, key, saddle reissue
	logic       second_q;
	logic       valid_s1, phase_s1, saddle_s1;
	logic [3:0] key_s1;
	logic [POS_W-1:0] row_s1, col_s1;
	smp_t       ll_s1, lr_s1, ur_s1, ul_s1, lev_s1;
	logic       accept;
	logic [3:0] key_in;
	logic       saddle_in, emit_in;

	assign busy = second_q;
	assign accept = start && !second_q;
	assign key_in = {upper_left > contour_level, upper_right > contour_level,
		lower_right > contour_level, lower_left > contour_level};
	assign saddle_in = (key_in == 4'd5) || (key_in == 4'd10);
	// key zero or fifteen also covers the level outside the corner range
	assign emit_in = (key_in != 4'd0) && (key_in != 4'd15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			second_q <= accept && saddle_in;
			valid_s1 <= accept ? emit_in : second_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			phase_s1  <= 1'b0;
			saddle_s1 <= saddle_in;
			key_s1    <= key_in;
			row_s1    <= sq_row;
			col_s1    <= sq_col;
			ll_s1     <= lower_left;
			lr_s1     <= lower_right;
			ur_s1     <= upper_right;
			ul_s1     <= upper_left;
			lev_s1    <= contour_level;
		end else if (second_q) begin
			phase_s1 <= 1'b1;
		end
	end

	// stage 2: side operands, edge products, border flags
	seg_t seg1;
	side_t side1 [2];
	logic [DW-1:0] num1 [2], den1 [2];
	logic [EDGE_W-1:0] cm1;
	logic [POS_W+1:0] blk_bot, blk_rgt, ras_bot, ras_rgt;
	logic blk1, ras1;

	assign seg1 = seg_sides(key_s1, phase_s1);
	assign side1[0] = seg1.first;
	assign side1[1] = seg1.second;
	assign cm1 = EDGE_W'(raster_columns_q) - EDGE_W'(1);
	assign blk_bot = (POS_W+2)'(block_first_row_q) + (POS_W+2)'(block_rows_q) - (POS_W+2)'(1);
	assign blk_rgt = (POS_W+2)'(block_first_col_q) + (POS_W+2)'(block_cols_q) - (POS_W+2)'(1);
	assign ras_bot = (POS_W+2)'(raster_rows_q) - (POS_W+2)'(2);
	assign ras_rgt = (POS_W+2)'(raster_columns_q) - (POS_W+2)'(2);

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			case (side1[l])
				SIDE_TOP: begin
					num1[l] = absd(lev_s1, ul_s1);
					den1[l] = absd(ur_s1, ul_s1);
				end
				SIDE_BOTTOM: begin
					num1[l] = absd(lev_s1, ll_s1);
					den1[l] = absd(lr_s1, ll_s1);
				end
				SIDE_LEFT: begin
					num1[l] = absd(lev_s1, ul_s1);
					den1[l] = absd(ll_s1, ul_s1);
				end
				default: begin
					num1[l] = absd(lev_s1, ur_s1);
					den1[l] = absd(lr_s1, ur_s1);
				end
			endcase
		end
		case (seg1.first)
			SIDE_TOP: begin
				blk1 = row_s1 == block_first_row_q;
				ras1 = row_s1 == '0;
			end
			SIDE_BOTTOM: begin
				blk1 = (POS_W+2)'(row_s1) == blk_bot;
				ras1 = (POS_W+2)'(row_s1) == ras_bot;
			end
			SIDE_LEFT: begin
				blk1 = col_s1 == block_first_col_q;
				ras1 = col_s1 == '0;
			end
			default: begin
				blk1 = (POS_W+2)'(col_s1) == blk_rgt;
				ras1 = (POS_W+2)'(col_s1) == ras_rgt;
			end
		endcase
	end

	logic valid_s2, last_s2, blk_s2, ras_s2;
	seg_t seg_s2;
	logic [POS_W-1:0] row_s2, col_s2;
	smp_t lev_s2;
	logic [DW-1:0] num_s2 [2], den_s2 [2];
	logic [EDGE_W-1:0] prod_rc_s2, prod_rr_s2, prod_rowc_s2, cm1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		last_s2      <= !saddle_s1 || phase_s1;
		blk_s2       <= blk1;
		ras_s2       <= ras1;
		seg_s2       <= seg1;
		row_s2       <= row_s1;
		col_s2       <= col_s1;
		lev_s2       <= lev_s1;
		num_s2       <= num1;
		den_s2       <= den1;
		cm1_s2       <= cm1;
		prod_rc_s2   <= EDGE_W'(row_s1) * cm1;
		prod_rr_s2   <= EDGE_W'(raster_rows_q) * cm1;
		prod_rowc_s2 <= EDGE_W'(row_s1) * EDGE_W'(raster_columns_q);
	end

	// edge index sum, feeds the first divider stage
	logic [EDGE_W-1:0] edge_base, edge2;
	meta_t meta2;

	always_comb begin
		edge_base = prod_rr_s2 + prod_rowc_s2 + EDGE_W'(col_s2);
		case (seg_s2.first)
			SIDE_TOP:    edge2 = prod_rc_s2 + EDGE_W'(col_s2);
			SIDE_BOTTOM: edge2 = prod_rc_s2 + cm1_s2 + EDGE_W'(col_s2);
			SIDE_LEFT:   edge2 = edge_base;
			default:     edge2 = edge_base + EDGE_W'(1);
		endcase
		meta2.row        = row_s2;
		meta2.col        = col_s2;
		meta2.entry_side = seg_s2.first;
		meta2.exit_side  = seg_s2.second;
		meta2.last       = last_s2;
		meta2.edge_idx   = edge2;
		meta2.blk        = blk_s2;
		meta2.ras        = ras_s2;
	end

	// restoring dividers, one quotient bit per stage, two lanes
	logic              dv_valid_s [NS];
	meta_t             dv_meta_s [NS];
	smp_t              dv_lev_s [NS];
	logic [DW:0]       dv_rem_s [NS][2];
	logic [FRAC_BITS:0] dv_quo_s [NS][2];
	logic [DW-1:0]     dv_den_s [NS][2];
	logic              dv_zero_s [NS][2];

	for (genvar k = 0; k < NS; k++) begin : g_div
		logic              v_in;
		meta_t             m_in;
		smp_t              lv_in;
		logic [DW:0]       r_in [2];
		logic [FRAC_BITS:0] q_in [2];
		logic [DW-1:0]     d_in [2];
		logic              z_in [2];
		logic [DW:0]       r_nx [2];
		logic              ge [2];

		if (k == 0) begin : g_head
			always_comb begin
				v_in  = valid_s2;
				m_in  = meta2;
				lv_in = lev_s2;
				for (int l = 0; l < 2; l++) begin
					r_in[l] = (DW+1)'(num_s2[l]);
					q_in[l] = '0;
					d_in[l] = den_s2[l];
					z_in[l] = den_s2[l] == '0;
				end
			end
		end else begin : g_tail
			always_comb begin
				v_in  = dv_valid_s[k-1];
				m_in  = dv_meta_s[k-1];
				lv_in = dv_lev_s[k-1];
				for (int l = 0; l < 2; l++) begin
					r_in[l] = dv_rem_s[k-1][l];
					q_in[l] = dv_quo_s[k-1][l];
					d_in[l] = dv_den_s[k-1][l];
					z_in[l] = dv_zero_s[k-1][l];
				end
			end
		end

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				ge[l]   = r_in[l] >= (DW+1)'(d_in[l]);
				r_nx[l] = ge[l] ? r_in[l] - (DW+1)'(d_in[l]) : r_in[l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_valid_s[k] <= 1'b0;
			else dv_valid_s[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			dv_meta_s[k] <= m_in;
			dv_lev_s[k]  <= lv_in;
			for (int l = 0; l < 2; l++) begin
				dv_rem_s[k][l]  <= {r_nx[l][DW-1:0], 1'b0};
				dv_quo_s[k][l]  <= {q_in[l][FRAC_BITS-1:0], ge[l]};
				dv_den_s[k][l]  <= d_in[l];
				dv_zero_s[k][l] <= z_in[l];
			end
		end
	end

	// point assembly and output register
	meta_t mf;
	logic [FRAC_BITS:0] tf [2];
	logic [COORD_W-1:0] r_fx, c_fx, one_fx, px [2], py [2];
	side_t sf [2];

	assign mf = dv_meta_s[NS-1];
	assign sf[0] = mf.entry_side;
	assign sf[1] = mf.exit_side;
	assign r_fx = COORD_W'(mf.row) << FRAC_BITS;
	assign c_fx = COORD_W'(mf.col) << FRAC_BITS;
	assign one_fx = COORD_W'(1) << FRAC_BITS;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (dv_zero_s[NS-1][l]) tf[l] = '0;
			else if (dv_quo_s[NS-1][l] > T_ONE) tf[l] = T_ONE;
			else tf[l] = dv_quo_s[NS-1][l];
			case (sf[l])
				SIDE_TOP: begin
					px[l] = c_fx + COORD_W'(tf[l]);
					py[l] = r_fx;
				end
				SIDE_BOTTOM: begin
					px[l] = c_fx + COORD_W'(tf[l]);
					py[l] = r_fx + one_fx;
				end
				SIDE_LEFT: begin
					px[l] = c_fx;
					py[l] = r_fx + COORD_W'(tf[l]);
				end
				default: begin
					px[l] = c_fx + one_fx;
					py[l] = r_fx + COORD_W'(tf[l]);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid <= 1'b0;
		else valid <= dv_valid_s[NS-1];
	end

	always_ff @(posedge clk) begin
		start_x        <= px[0];
		start_y        <= py[0];
		end_x          <= px[1];
		end_y          <= py[1];
		start_edge     <= mf.edge_idx;
		entry_side     <= mf.entry_side;
		exit_side      <= mf.exit_side;
		block_inbound  <= mf.blk;
		raster_inbound <= mf.ras;
		level_echo     <= dv_lev_s[NS-1];
		last_segment   <= mf.last;
	end

	`MSC_ASSERT_NEXT(a_saddle_reissue, busy, valid_s1 && phase_s1, "saddle second segment not issued")
	`MSC_ASSERT_NEXT(a_busy_one_cycle, busy, !busy, "busy held longer than one cycle")
	`MSC_ASSERT_NEXT(a_pair_contiguous, valid && !last_segment, valid && last_segment, "saddle pair split")
	`MSC_ASSERT_NOW(a_sides_differ, valid, entry_side != exit_side, "segment starts and ends on one side")
endmodule

FILE: tb/marching_squares_cell_unit_test.sv
// self-checking testbench for the marching squares cell unit
`timescale 1ns / 100ps
module marching_squares_cell_unit_test import msc_pkg::*; ();

	localparam int LIMIT = 400000;
	localparam int DRAIN = 24;

	typedef struct {
		logic [11:0] row, col;
		logic signed [15:0] ll, lr, ur, ul, lev;
	} square_t;

	typedef struct {
		logic [28:0] sx, sy, ex, ey;
		logic [25:0] edge_idx;
		side_t ss, es;
		logic blk, ras, last;
		logic [15:0] lev;
	} segment_t;

	typedef struct {
		square_t sq;
		int n;
		side_t s0, e0;
	} directed_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [11:0] sq_row = 0, sq_col = 0;
	logic signed [15:0] lower_left = 0, lower_right = 0, upper_right = 0, upper_left = 0;
	logic signed [15:0] contour_level = 0;
	logic cfg_we = 0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data = '0;
	logic valid;
	logic [COORD_W-1:0] start_x, start_y, end_x, end_y;
	logic [EDGE_W-1:0] start_edge;
	logic [1:0] entry_side, exit_side;
	logic block_inbound, raster_inbound, last_segment;
	logic signed [15:0] level_echo;

	logic [12:0] ras_cols = 4096, ras_rows = 4096;
	logic [11:0] blk_row0 = 0, blk_col0 = 0, blk_rows = 32, blk_cols = 32;

	segment_t pending_segments[$];
	directed_row_t directed[$];
	int errors = 0, cycles = 0, n_items = 0, n_segments = 0, n_saddles = 0, n_empty = 0;

	marching_squares_cell_unit uut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[marching_squares_cell_unit] ERROR");
			$finish;
		end
	end

	// fraction along a->b where the level crosses, 16 fraction bits
	function automatic longint crossing_frac(longint a, longint b, longint lev);
		longint den, t;
		den = (b >= a) ? b - a : a - b;
		if (den == 0) return 0;
		t = (((lev >= a) ? lev - a : a - lev) << 16) / den;
		return (t > 65536) ? 65536 : t;
	endfunction

	function automatic void side_point(side_t sd, square_t q, output logic [28:0] x,
			output logic [28:0] y);
		longint r, c;
		longint unsigned px, py;
		r = longint'(q.row) << 16;
		c = longint'(q.col) << 16;
		case (sd)
			SIDE_TOP: begin
				px = c + crossing_frac(q.ul, q.ur, q.lev); py = r;
			end
			SIDE_BOTTOM: begin
				px = c + crossing_frac(q.ll, q.lr, q.lev); py = r + 65536;
			end
			SIDE_LEFT: begin
				px = c; py = r + crossing_frac(q.ul, q.ll, q.lev);
			end
			default: begin
				px = c + 65536; py = r + crossing_frac(q.ur, q.lr, q.lev);
			end
		endcase
		x = px[28:0];
		y = py[28:0];
	endfunction

	function automatic logic [25:0] edge_number(side_t sd, square_t q);
		longint unsigned cm1, rr, cc, v;
		cm1 = longint'(ras_cols) - 1;
		rr = q.row;
		cc = q.col;
		case (sd)
			SIDE_TOP:    v = rr * cm1 + cc;
			SIDE_BOTTOM: v = (rr + 1) * cm1 + cc;
			SIDE_LEFT:   v = longint'(ras_rows) * cm1 + rr * longint'(ras_cols) + cc;
			default:     v = longint'(ras_rows) * cm1 + rr * longint'(ras_cols) + cc + 1;
		endcase
		return v[25:0];
	endfunction

	function automatic logic on_block_edge(side_t sd, square_t q);
		case (sd)
			SIDE_TOP:    return longint'(q.row) == longint'(blk_row0);
			SIDE_BOTTOM: return longint'(q.row) == longint'(blk_row0) + longint'(blk_rows) - 1;
			SIDE_LEFT:   return longint'(q.col) == longint'(blk_col0);
			default:     return longint'(q.col) == longint'(blk_col0) + longint'(blk_cols) - 1;
		endcase
	endfunction

	function automatic logic on_raster_edge(side_t sd, square_t q);
		case (sd)
			SIDE_TOP:    return q.row == 0;
			SIDE_BOTTOM: return longint'(q.row) == longint'(ras_rows) - 2;
			SIDE_LEFT:   return q.col == 0;
			default:     return longint'(q.col) == longint'(ras_cols) - 2;
		endcase
	endfunction

	// works out the segments of one square and queues them; returns their number
	function automatic int trace_square(square_t q, output side_t s0, output side_t e0);
		logic [3:0] key;
		side_t sides[4];
		int n;
		longint mn, mx;
		segment_t g;
		mn = q.ll; mx = q.ll;
		if (q.lr < mn) mn = q.lr;
		if (q.ur < mn) mn = q.ur;
		if (q.ul < mn) mn = q.ul;
		if (q.lr > mx) mx = q.lr;
		if (q.ur > mx) mx = q.ur;
		if (q.ul > mx) mx = q.ul;
		s0 = SIDE_TOP;
		e0 = SIDE_TOP;
		if (q.lev < mn || q.lev > mx) return 0;
		key = {q.ul > q.lev, q.ur > q.lev, q.lr > q.lev, q.ll > q.lev};
		n = 1;
		sides = '{SIDE_TOP, SIDE_TOP, SIDE_TOP, SIDE_TOP};
		case (key)
			4'd1:  sides = '{SIDE_LEFT, SIDE_BOTTOM, SIDE_TOP, SIDE_TOP};
			4'd2:  sides = '{SIDE_BOTTOM, SIDE_RIGHT, SIDE_TOP, SIDE_TOP};
			4'd3:  sides = '{SIDE_LEFT, SIDE_RIGHT, SIDE_TOP, SIDE_TOP};
			4'd4:  sides = '{SIDE_RIGHT, SIDE_TOP, SIDE_TOP, SIDE_TOP};
			4'd5: begin
				sides = '{SIDE_LEFT, SIDE_TOP, SIDE_RIGHT, SIDE_BOTTOM}; n = 2;
			end
			4'd6:  sides = '{SIDE_BOTTOM, SIDE_TOP, SIDE_TOP, SIDE_TOP};
			4'd7:  sides = '{SIDE_LEFT, SIDE_TOP, SIDE_TOP, SIDE_TOP};
			4'd8:  sides = '{SIDE_TOP, SIDE_LEFT, SIDE_TOP, SIDE_TOP};
			4'd9:  sides = '{SIDE_TOP, SIDE_BOTTOM, SIDE_TOP, SIDE_TOP};
			4'd10: begin
				sides = '{SIDE_TOP, SIDE_RIGHT, SIDE_BOTTOM, SIDE_LEFT}; n = 2;
			end
			4'd11: sides = '{SIDE_TOP, SIDE_RIGHT, SIDE_TOP, SIDE_TOP};
			4'd12: sides = '{SIDE_RIGHT, SIDE_LEFT, SIDE_TOP, SIDE_TOP};
			4'd13: sides = '{SIDE_RIGHT, SIDE_BOTTOM, SIDE_TOP, SIDE_TOP};
			4'd14: sides = '{SIDE_BOTTOM, SIDE_LEFT, SIDE_TOP, SIDE_TOP};
			default: n = 0;
		endcase
		s0 = sides[0];
		e0 = sides[1];
		for (int k = 0; k < n; k++) begin
			g.ss = sides[2*k];
			g.es = sides[2*k+1];
			side_point(g.ss, q, g.sx, g.sy);
			side_point(g.es, q, g.ex, g.ey);
			g.edge_idx = edge_number(g.ss, q);
			g.blk = on_block_edge(g.ss, q);
			g.ras = on_raster_edge(g.ss, q);
			g.lev = q.lev;
			g.last = (k == n - 1);
			pending_segments.insert(pending_segments.size(), g);
		end
		return n;
	endfunction

	always @(posedge clk) begin
		segment_t g;
		if (valid) begin
			if (pending_segments.size() == 0) begin
				errors++;
				if (errors <= 10) $display("segment with none expected at cycle %0d", cycles);
			end else begin
				g = pending_segments.pop_front();
				if (start_x !== g.sx || start_y !== g.sy || end_x !== g.ex || end_y !== g.ey ||
						start_edge !== g.edge_idx || entry_side !== g.ss || exit_side !== g.es ||
						block_inbound !== g.blk || raster_inbound !== g.ras ||
						level_echo !== g.lev || last_segment !== g.last) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch: exp sx %h sy %h ex %h ey %h edge %h sides %0d/%0d",
							g.sx, g.sy, g.ex, g.ey, g.edge_idx, g.ss, g.es);
						$display("   blk %b ras %b lev %h last %b", g.blk, g.ras, g.lev, g.last);
						$display("  got sx %h sy %h ex %h ey %h edge %h sides %0d/%0d",
							start_x, start_y, end_x, end_y, start_edge, entry_side, exit_side);
						$display("   blk %b ras %b lev %h last %b", block_inbound,
							raster_inbound, level_echo, last_segment);
					end
				end
			end
		end
	end

	// presents one request and holds it until the block takes it
	task automatic send_square(square_t q, output int n, output side_t s0, output side_t e0);
		sq_row <= q.row;
		sq_col <= q.col;
		lower_left <= q.ll;
		lower_right <= q.lr;
		upper_right <= q.ur;
		upper_left <= q.ul;
		contour_level <= q.lev;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		n = trace_square(q, s0, e0);
		n_items++;
		n_segments += n;
		if (n == 2) n_saddles++;
		if (n == 0) n_empty++;
	endtask

	task automatic maybe_gap(bit allow);
		if (allow && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic drain;
		start <= 0;
		@(posedge clk);
		while (pending_segments.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// write enable stays high across back-to-back writes, configure drops it
	task automatic write_reg(reg_idx_t idx, logic [12:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			REG_RASTER_COLUMNS:  ras_cols = v;
			REG_RASTER_ROWS:     ras_rows = v;
			REG_BLOCK_FIRST_ROW: blk_row0 = v[11:0];
			REG_BLOCK_FIRST_COL: blk_col0 = v[11:0];
			REG_BLOCK_ROWS:      blk_rows = v[11:0];
			default:             blk_cols = v[11:0];
		endcase
	endtask

	task automatic configure(int cols, int rows, int r0, int c0, int br, int bc);
		write_reg(REG_RASTER_COLUMNS, 13'(cols));
		write_reg(REG_RASTER_ROWS, 13'(rows));
		write_reg(REG_BLOCK_FIRST_ROW, 13'(r0));
		write_reg(REG_BLOCK_FIRST_COL, 13'(c0));
		write_reg(REG_BLOCK_ROWS, 13'(br));
		write_reg(REG_BLOCK_COLS, 13'(bc));
		cfg_we <= 0;
	endtask

	function automatic logic signed [15:0] clamp16(int v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return 16'(v);
	endfunction

	// position biased toward block and raster borders
	function automatic logic [11:0] pick_pos(int first, int count, int dim);
		int v;
		case ($urandom_range(0, 4))
			0: v = $urandom_range(0, 4094);
			1: v = first + $urandom_range(0, 1);
			2: v = first + count - 1 - $urandom_range(0, 1);
			3: v = dim - 2 - $urandom_range(0, 1);
			default: v = $urandom_range(0, 2);
		endcase
		if (v < 0) v = 0;
		if (v > 4094) v = 4094;
		return 12'(v);
	endfunction

	function automatic square_t random_square();
		square_t q;
		int base, spread, mn, mx, m;
		q.row = pick_pos(blk_row0, blk_rows, ras_rows);
		q.col = pick_pos(blk_col0, blk_cols, ras_cols);
		m = $urandom_range(0, 19);
		if (m < 3) begin
			q.ll = 16'($urandom); q.lr = 16'($urandom); q.ur = 16'($urandom);
			q.ul = 16'($urandom);
			q.lev = 16'($urandom);
		end else begin
			base = int'($urandom_range(0, 65535)) - 32768;
			spread = 1 << $urandom_range(0, 16);
			q.ll = clamp16(base + int'($urandom_range(0, 2 * spread)) - spread);
			q.lr = clamp16(base + int'($urandom_range(0, 2 * spread)) - spread);
			q.ur = clamp16(base + int'($urandom_range(0, 2 * spread)) - spread);
			q.ul = clamp16(base + int'($urandom_range(0, 2 * spread)) - spread);
			mn = q.ll; mx = q.ll;
			if (q.lr < mn) mn = q.lr;
			if (q.ur < mn) mn = q.ur;
			if (q.ul < mn) mn = q.ul;
			if (q.lr > mx) mx = q.lr;
			if (q.ur > mx) mx = q.ur;
			if (q.ul > mx) mx = q.ul;
			// level sitting exactly on a corner now and then
			if (m < 6) begin
				case ($urandom_range(0, 3))
					0: q.lev = q.ll;
					1: q.lev = q.lr;
					2: q.lev = q.ur;
					default: q.lev = q.ul;
				endcase
			end else begin
				q.lev = 16'(mn + int'($urandom_range(0, mx - mn)));
			end
		end
		return q;
	endfunction

	task automatic add_row(int r, int c, int ll, int lr, int ur, int ul, int lev, int n,
			side_t s0, side_t e0);
		directed_row_t d;
		d.sq = '{12'(r), 12'(c), 16'(ll), 16'(lr), 16'(ur), 16'(ul), 16'(lev)};
		d.n = n;
		d.s0 = s0;
		d.e0 = e0;
		directed.insert(directed.size(), d);
	endtask

	initial begin
		int n;
		side_t s0, e0;
		square_t q;
		add_row(0, 0, 10, 20, 30, 40, 5, 0, SIDE_TOP, SIDE_TOP);
		add_row(0, 0, 10, 20, 30, 40, 41, 0, SIDE_TOP, SIDE_TOP);
		add_row(4094, 4094, 7, 7, 7, 7, 7, 0, SIDE_TOP, SIDE_TOP);
		add_row(5, 5, 100, -100, -100, -100, 0, 1, SIDE_LEFT, SIDE_BOTTOM);
		add_row(5, 6, -100, 100, -100, -100, 0, 1, SIDE_BOTTOM, SIDE_RIGHT);
		add_row(6, 5, -100, -100, 100, -100, 0, 1, SIDE_RIGHT, SIDE_TOP);
		add_row(31, 31, -100, -100, -100, 100, 0, 1, SIDE_TOP, SIDE_LEFT);
		add_row(31, 0, 100, 100, 100, -100, 0, 1, SIDE_LEFT, SIDE_TOP);
		add_row(0, 31, 100, 100, -100, 100, 0, 1, SIDE_TOP, SIDE_RIGHT);
		add_row(1, 31, 100, -100, 100, 100, 0, 1, SIDE_RIGHT, SIDE_BOTTOM);
		add_row(31, 1, -100, 100, 100, 100, 0, 1, SIDE_BOTTOM, SIDE_LEFT);
		add_row(2, 3, 100, 100, -100, -100, 0, 1, SIDE_LEFT, SIDE_RIGHT);
		add_row(3, 2, -100, 100, 100, -100, 0, 1, SIDE_BOTTOM, SIDE_TOP);
		add_row(4093, 4094, 100, -100, -100, 100, 0, 1, SIDE_TOP, SIDE_BOTTOM);
		add_row(4094, 4093, -100, -100, 100, 100, 0, 1, SIDE_RIGHT, SIDE_LEFT);
		add_row(0, 0, 100, -100, 100, -100, 0, 2, SIDE_LEFT, SIDE_TOP);
		add_row(31, 31, -100, 100, -100, 100, 0, 2, SIDE_TOP, SIDE_RIGHT);
		add_row(4094, 4094, 32767, -32768, -32768, -32768, -32768, 1, SIDE_LEFT,
			SIDE_BOTTOM);
		add_row(7, 7, 50, 0, 0, 0, 0, 1, SIDE_LEFT, SIDE_BOTTOM);
		add_row(7, 8, 0, 50, 50, 50, 50, 0, SIDE_TOP, SIDE_TOP);
		add_row(4094, 0, -32768, 32767, -32768, 32767, 0, 2, SIDE_TOP, SIDE_RIGHT);
		add_row(0, 4094, 32767, 32767, -32768, -32768, 32767, 0, SIDE_TOP, SIDE_TOP);

		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_square(directed[i].sq, n, s0, e0);
			if (n != directed[i].n || (n > 0 && (s0 != directed[i].s0 || e0 != directed[i].e0)))
					begin
				errors++;
				if (errors <= 10)
					$display("square %0d: %0d segments from %0d to %0d, wanted %0d from %0d to %0d",
						i, n, s0, e0, directed[i].n, directed[i].s0, directed[i].e0);
			end
			maybe_gap(1);
		end

		for (int ph = 0; ph < 8; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: configure(2, 2, 0, 0, 1, 1);
					2: configure(4096, 4096, 4094, 4094, 4095, 4095);
					3: configure(8191, 0, 4095, 0, 0, 4095);
					default: configure($urandom_range(2, 4096), $urandom_range(2, 4096),
						$urandom_range(0, 4094), $urandom_range(0, 4094),
						$urandom_range(1, 4095), $urandom_range(1, 4095));
				endcase
			end
			for (int i = 0; i < 228; i++) begin
				q = random_square();
				send_square(q, n, s0, e0);
				// one hold-off until everything in flight is out
				if (ph == 4 && i == 100) begin
					start <= 0;
					@(posedge clk);
					while (pending_segments.size() != 0) @(posedge clk);
				end
				maybe_gap(ph < 7);
			end
		end

		start <= 0;
		@(posedge clk);
		while (pending_segments.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("%0d squares sent over 8 register settings: %0d segments, %0d saddles, %0d empty",
			n_items, n_segments, n_saddles, n_empty);
		if (errors == 0) begin
			$display("[marching_squares_cell_unit] OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("[marching_squares_cell_unit] ERROR");
		end
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+sv
sv/msc_pkg.sv
sv/marching_squares_cell_unit.sv
tb/marching_squares_cell_unit_test.sv
